// File: design/bte_pkg.sv
// Shared types and constants of the bitmap text pixel emitter.
package bte_pkg;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_FONT  = 2'd2;

  localparam logic REG_CHAR_PITCH = 1'b0;
  localparam logic REG_LINE_PITCH = 1'b1;

  localparam logic [7:0] RST_CHAR_PITCH = 8'd6;
  localparam logic [7:0] RST_LINE_PITCH = 8'd14;

  localparam logic [7:0] CODE_FIRST   = 8'd32;
  localparam logic [7:0] CODE_LAST    = 8'd127;
  localparam logic [7:0] CODE_ESC     = 8'd27;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_HASH    = 8'd35;
  localparam logic [7:0] CODE_ZERO    = 8'd48;
  localparam logic [7:0] CODE_NINE    = 8'd57;
  localparam logic [7:0] CODE_UPPER_A = 8'd65;
  localparam logic [7:0] CODE_UPPER_F = 8'd70;

  localparam logic [2:0] HEX_DIGITS_MAX = 3'd6;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_DIGITS = 3'b100
  } parse_mode_e;

  typedef struct packed {
    logic        start;
    logic [7:0]  glyph;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] color;
  } glyph_req_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] color;
    logic        last;
  } pixel_t;

endpackage

// File: design/bte_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 480
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/bte_glyph.sv
// Glyph sequencer: loads the glyph columns from the font RAM and emits lit pixels.
module bte_glyph import bte_pkg::*; #(
  parameter int GLYPH_COLUMNS = 5,
  parameter int GLYPH_ROWS    = 7,
  parameter int AW            = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  glyph_req_t    req_i,
  output logic          busy_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output logic          pix_valid_o,
  input  logic          pix_ready_i,
  output pixel_t        pix_o
);

  localparam int CW = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
  localparam logic [CW-1:0] LAST_COL = CW'(GLYPH_COLUMNS - 1);
  localparam logic [7:0] ROW_MASK = 8'((16'd1 << GLYPH_ROWS) - 16'd1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } seq_state_e;

  seq_state_e    state_q, state_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] rd_col_q, rd_col_d;
  logic [CW-1:0] pend_col_q;
  logic          pend_q;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    clr_q, clr_d;
  logic [15:0]   x_q, x_d, y_q, y_d;
  logic [31:0]   color_q, color_d;
  logic [7:0]    glyph_buf_q [GLYPH_COLUMNS];
  logic          ovalid_q, ovalid_d;
  pixel_t        pix_q, pix_d;

  logic [7:0] cur_bits;
  logic [7:0] low_bit;
  logic [2:0] row;
  logic       later_any;
  logic       out_free;
  logic       push;

  always_comb begin
    cur_bits  = glyph_buf_q[col_q] & ~clr_q;
    low_bit   = cur_bits & (~cur_bits + 8'd1);
    row       = 3'd0;
    later_any = 1'b0;
    for (int r = 0; r < 8; r++) begin
      if (low_bit[r]) begin
        row = 3'(r);
      end
    end
    for (int k = 0; k < GLYPH_COLUMNS; k++) begin
      if (k > int'(col_q)) begin
        later_any = later_any | (glyph_buf_q[k] != 8'd0);
      end
    end
  end

  assign out_free = !ovalid_q || pix_ready_i;
  assign push     = (state_q == S_EMIT) && (cur_bits != 8'd0) && out_free;

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    rd_col_d  = rd_col_q;
    col_d     = col_q;
    clr_d     = clr_q;
    x_d       = x_q;
    y_d       = y_q;
    color_d   = color_q;
    rd_en_o   = 1'b0;
    rd_addr_o = base_q + AW'(rd_col_q);
    pix_d     = pix_q;
    ovalid_d  = ovalid_q && !pix_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          base_d   = AW'(int'(req_i.glyph) * GLYPH_COLUMNS);
          x_d      = req_i.x;
          y_d      = req_i.y;
          color_d  = req_i.color;
          rd_col_d = '0;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        rd_en_o = 1'b1;
        if (rd_col_q == LAST_COL) begin
          state_d = S_WAIT;
        end else begin
          rd_col_d = rd_col_q + CW'(1);
        end
      end
      S_WAIT: begin
        col_d   = '0;
        clr_d   = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (cur_bits == 8'd0) begin
          if (col_q == LAST_COL) begin
            state_d = S_IDLE;
          end else begin
            col_d = col_q + CW'(1);
            clr_d = '0;
          end
        end else if (out_free) begin
          pix_d.x     = x_q + 16'(col_q);
          pix_d.y     = y_q + 16'(row);
          pix_d.color = color_q;
          pix_d.last  = ((cur_bits & (cur_bits - 8'd1)) == 8'd0) && !later_any;
          ovalid_d    = 1'b1;
          clr_d       = clr_q | low_bit;
          if (pix_d.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= (state_q == S_LOAD);
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    rd_col_q   <= rd_col_d;
    pend_col_q <= rd_col_q;
    col_q      <= col_d;
    clr_q      <= clr_d;
    x_q        <= x_d;
    y_q        <= y_d;
    color_q    <= color_d;
    pix_q      <= pix_d;
    if (pend_q) begin
      glyph_buf_q[pend_col_q] <= rd_data_i & ROW_MASK;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign pix_valid_o = ovalid_q;
  assign pix_o       = pix_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == S_IDLE)
    else $error("glyph request while the sequencer is busy");

  a_last_ends_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && pix_d.last) |=> state_q == S_IDLE)
    else $error("sequencer kept running after the final pixel");

  a_clear_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ((clr_q & ~glyph_buf_q[col_q]) == 8'd0))
    else $error("emitted row mask is not within the column bits");

endmodule

// File: design/bitmap_text_pixel_emitter.sv
// Top level of the bitmap text pixel emitter: command parser, font RAM and glyph sequencer.
//
// Input transactions on s_axis carry a command in tuser: begin string (loads the cursor,
// line start and color), string character, or font byte write. tlast marks the last
// character of a string. Each drawing character produces one m_axis transaction per lit
// glyph pixel, in column order and bit 0 first, with tlast on its final pixel. The user
// writes the char_pitch and line_pitch registers through the cfg port only while idle;
// the block itself does not enforce it.
//
// Begin, font writes and characters that draw nothing leave the input ready for the next
// transaction. A drawing character is accepted, the font RAM is read once per column,
// the last read lands in the glyph buffer, and then its lit pixels are emitted, with a
// step for each column before the final pixel. The pace is set by the single read port
// of the font RAM and the one-pixel-per-cycle emit loop, which waits while m_axis stalls.
// The next transaction is accepted as soon as the final pixel sits in the output register.
// Reset clears the cursor, color and parser and sets the pitches to 6 and 14; the font
// RAM contents are undefined until written. When m_axis stalls, the output register
// holds its pixel and the sequencer waits; no pixel is lost.
module bitmap_text_pixel_emitter import bte_pkg::*; #(
  parameter int GLYPH_COUNT   = 96,
  parameter int GLYPH_COLUMNS = 5,
  parameter int GLYPH_ROWS    = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], start_x[23:8], start_y[39:24], start_color[71:40],
  // font_index[80:72], font_bits[88:81], zero padding[95:89]
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], pixel_color[63:32]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_COLUMNS;
  localparam int AW = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;

  logic [7:0]  char_pitch_q, line_pitch_q;
  logic [15:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d, line_x_q, line_x_d;
  logic [31:0] color_q, color_d;
  parse_mode_e mode_q, mode_d;
  logic [2:0]  hex_cnt_q, hex_cnt_d;
  logic [23:0] hex_q, hex_d;

  logic          in_acc;
  logic [7:0]    in_char;
  logic [7:0]    glyph_idx;
  logic          drawable;
  logic          is_digit;
  logic [3:0]    digit_val;
  logic [23:0]   hex_shift;
  logic          handled;
  logic          font_we;
  glyph_req_t    req;
  logic          glyph_busy;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  pixel_t        pix;

  assign s_axis_tready = !glyph_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_char       = s_axis_tdata[7:0];
  assign glyph_idx     = in_char - CODE_FIRST;
  assign drawable      = (in_char >= CODE_FIRST) && (in_char <= CODE_LAST) &&
                         (int'(glyph_idx) < GLYPH_COUNT);
  assign is_digit      = ((in_char >= CODE_ZERO) && (in_char <= CODE_NINE)) ||
                         ((in_char >= CODE_UPPER_A) && (in_char <= CODE_UPPER_F));
  assign digit_val     = (in_char <= CODE_NINE) ? in_char[3:0] : in_char[3:0] + 4'd9;
  assign hex_shift     = {hex_q[19:0], digit_val};

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    line_x_d  = line_x_q;
    color_d   = color_q;
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    hex_d     = hex_q;
    font_we   = 1'b0;
    handled   = 1'b0;
    req.start = 1'b0;
    req.glyph = glyph_idx;
    req.x     = cur_x_q;
    req.y     = cur_y_q;
    req.color = color_q;
    if (in_acc) begin
      unique case (s_axis_tuser)
        CMD_BEGIN: begin
          cur_x_d   = s_axis_tdata[23:8];
          line_x_d  = s_axis_tdata[23:8];
          cur_y_d   = s_axis_tdata[39:24];
          color_d   = s_axis_tdata[71:40];
          mode_d    = MODE_NORMAL;
          hex_cnt_d = '0;
          hex_d     = '0;
        end
        CMD_FONT: begin
          font_we = (int'(s_axis_tdata[80:72]) < FONT_DEPTH);
        end
        CMD_CHAR: begin
          mode_d = MODE_NORMAL;
          unique case (mode_q)
            MODE_DIGITS: begin
              if (is_digit && (hex_cnt_q < HEX_DIGITS_MAX)) begin
                hex_d     = hex_shift;
                color_d   = 32'(hex_shift);
                hex_cnt_d = hex_cnt_q + 3'd1;
                mode_d    = (hex_cnt_q + 3'd1 >= HEX_DIGITS_MAX) ? MODE_NORMAL : MODE_DIGITS;
                handled   = 1'b1;
              end
            end
            MODE_ESCAPE: begin
              if ((in_char == CODE_HASH) && !s_axis_tlast) begin
                mode_d    = MODE_DIGITS;
                hex_cnt_d = '0;
                hex_d     = '0;
                color_d   = '0;
                handled   = 1'b1;
              end
            end
            default: ;
          endcase
          if (!handled) begin
            if ((in_char == CODE_ESC) && !s_axis_tlast) begin
              mode_d = MODE_ESCAPE;
            end else if (in_char == CODE_NEWLINE) begin
              cur_x_d = line_x_q;
              cur_y_d = cur_y_q + 16'(line_pitch_q);
            end else begin
              req.start = drawable;
              cur_x_d   = cur_x_q + 16'(char_pitch_q);
            end
          end
          if (s_axis_tlast) begin
            mode_d    = MODE_NORMAL;
            hex_cnt_d = '0;
            hex_d     = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pitch_q <= RST_CHAR_PITCH;
      line_pitch_q <= RST_LINE_PITCH;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      line_x_q     <= '0;
      color_q      <= '0;
      mode_q       <= MODE_NORMAL;
      hex_cnt_q    <= '0;
      hex_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CHAR_PITCH: char_pitch_q <= cfg_data_i;
          REG_LINE_PITCH: line_pitch_q <= cfg_data_i;
          default: ;
        endcase
      end
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      line_x_q  <= line_x_d;
      color_q   <= color_d;
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      hex_q     <= hex_d;
    end
  end

  bte_ram #(
    .WIDTH(8),
    .DEPTH(FONT_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (AW'(s_axis_tdata[80:72])),
    .wdata_i (s_axis_tdata[88:81]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bte_glyph #(
    .GLYPH_COLUMNS(GLYPH_COLUMNS),
    .GLYPH_ROWS   (GLYPH_ROWS),
    .AW           (AW)
  ) u_glyph (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .busy_o      (glyph_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .pix_valid_o (m_axis_tvalid),
    .pix_ready_i (m_axis_tready),
    .pix_o       (pix)
  );

  assign m_axis_tdata = {pix.color, pix.y, pix.x};
  assign m_axis_tlast = pix.last;

  a_hex_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_cnt_q <= HEX_DIGITS_MAX)
    else $error("hex digit count beyond six");

  a_digits_mode_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DIGITS) |-> (hex_cnt_q < HEX_DIGITS_MAX))
    else $error("digit mode held after the sixth digit");

  a_font_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    font_we |-> (!glyph_busy && !rd_en))
    else $error("font write while a glyph is being read");

endmodule
